### hw/rtl/sus_pkg.sv
// Shared constants, codes and types for the sorted unique set core.
`default_nettype none
package sus_pkg;

  // Store geometry and field widths
  localparam int CAPACITY  = 64;
  localparam int VAL_W     = 16;
  localparam int OP_W      = 2;
  localparam int ST_W      = 2;
  localparam int CNT_OUT_W = 7;
  localparam int CNT_W     = $clog2(CAPACITY + 1);

  // Operation codes; code 3 acts as a search
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

  // Result status codes
  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_MISS = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL = 2'd2;

  // Sequencer states
  typedef enum logic {
    FSM_IDLE,
    FSM_COMMIT
  } fsm_state_t;

  // Command broadcast from the sequencer to every cell
  typedef struct packed {
    logic             cmp;
    logic             ins;
    logic             del;
    logic [VAL_W-1:0] key;
  } cell_cmd_t;

endpackage
`default_nettype wire

### hw/rtl/sus_cell.sv
// One compare-and-shift cell of the sorted store chain.
`default_nettype none
module sus_cell (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire sus_pkg::cell_cmd_t       cmd,
  input  wire logic                     occ,
  input  wire logic [sus_pkg::VAL_W-1:0] left_val,
  input  wire logic                     left_lt,
  input  wire logic [sus_pkg::VAL_W-1:0] right_val,
  output logic      [sus_pkg::VAL_W-1:0] cell_val,
  output logic                          cell_lt,
  output logic                          cell_eq
);
  import sus_pkg::*;

  logic [VAL_W-1:0] val_r, val_nxt;
  logic             lt_r, lt_nxt;
  logic             eq_r, eq_nxt;

  // Compare the held value against the key on a new transfer
  always_comb begin
    lt_nxt = lt_r;
    eq_nxt = eq_r;
    if (cmd.cmp) begin
      lt_nxt = occ && (val_r < cmd.key);
      eq_nxt = occ && (val_r == cmd.key);
    end
  end

  // Shift up for an insert, down for a delete; cells below the position hold.
  // On an insert the cell at the position (left neighbour below the key) takes the key.
  always_comb begin
    val_nxt = val_r;
    if (cmd.ins && !lt_r) begin
      val_nxt = left_lt ? cmd.key : left_val;
    end else if (cmd.del && !lt_r) begin
      val_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lt_r <= 1'b0;
      eq_r <= 1'b0;
    end else begin
      lt_r <= lt_nxt;
      eq_r <= eq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign cell_val = val_r;
  assign cell_lt  = lt_r;
  assign cell_eq  = eq_r;

endmodule
`default_nettype wire

### hw/rtl/sus_ctrl.sv
// Sequencer: accepts commands, decides the action, keeps the count, drives results.
`default_nettype none
module sus_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [sus_pkg::OP_W-1:0]      in_operation,
  input  wire logic [sus_pkg::VAL_W-1:0]     in_value,
  input  wire logic                          hit,
  output logic                               busy,
  output sus_pkg::cell_cmd_t                 cmd,
  output logic      [sus_pkg::CNT_W-1:0]     count,
  output logic                               out_strobe,
  output logic      [sus_pkg::ST_W-1:0]      out_status,
  output logic      [sus_pkg::CNT_OUT_W-1:0] out_entry_count
);
  import sus_pkg::*;

  fsm_state_t           state_r, state_nxt;
  logic [OP_W-1:0]      op_r, op_nxt;
  logic [VAL_W-1:0]     value_r, value_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 strobe_r, strobe_nxt;
  logic [ST_W-1:0]      status_r, status_nxt;
  logic [CNT_OUT_W-1:0] ocount_r, ocount_nxt;
  logic                 accept;
  logic                 full;
  logic                 ins_do;
  logic                 del_do;

  assign accept = start && (state_r == FSM_IDLE);
  assign full   = (count_r == CNT_W'(CAPACITY));
  assign ins_do = (state_r == FSM_COMMIT) && (op_r == OP_INSERT) && !hit && !full;
  assign del_do = (state_r == FSM_COMMIT) && (op_r == OP_DELETE) && hit;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FSM_IDLE: begin
        if (start) begin
          state_nxt = FSM_COMMIT;
        end
      end
      FSM_COMMIT: state_nxt = FSM_IDLE;
      default:    state_nxt = FSM_IDLE;
    endcase
  end

  // Outputs to the cells and the handshake
  always_comb begin
    cmd.cmp = 1'b0;
    cmd.ins = 1'b0;
    cmd.del = 1'b0;
    cmd.key = in_value;
    busy    = 1'b0;
    case (state_r)
      FSM_IDLE: begin
        cmd.cmp = start;
        cmd.key = in_value;
      end
      FSM_COMMIT: begin
        busy    = 1'b1;
        cmd.ins = ins_do;
        cmd.del = del_do;
        cmd.key = value_r;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  // Latch the command, update the count and form the result
  always_comb begin
    op_nxt     = op_r;
    value_nxt  = value_r;
    count_nxt  = count_r;
    strobe_nxt = 1'b0;
    status_nxt = status_r;
    ocount_nxt = ocount_r;
    if (accept) begin
      op_nxt    = in_operation;
      value_nxt = in_value;
    end
    if (ins_do) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (del_do) begin
      count_nxt = count_r - CNT_W'(1);
    end
    if (state_r == FSM_COMMIT) begin
      strobe_nxt = 1'b1;
      ocount_nxt = CNT_OUT_W'(count_nxt);
      case (op_r)
        OP_INSERT: status_nxt = hit ? ST_MISS : (full ? ST_FULL : ST_OK);
        OP_DELETE: status_nxt = hit ? ST_OK : ST_MISS;
        OP_SEARCH: status_nxt = hit ? ST_OK : ST_MISS;
        default:   status_nxt = hit ? ST_OK : ST_MISS;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= FSM_IDLE;
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    value_r  <= value_nxt;
    status_r <= status_nxt;
    ocount_r <= ocount_nxt;
  end

  assign count           = count_r;
  assign out_strobe      = strobe_r;
  assign out_status      = status_r;
  assign out_entry_count = ocount_r;

endmodule
`default_nettype wire

### hw/rtl/sorted_unique_set_core.sv
// Top level of the sorted unique set: a sequencer driving a chain of store cells.
//
//   channel  ports                                   handshake
//   input    in_operation, in_value                  start high, busy low
//   result   out_status, out_entry_count             out_strobe, one cycle
//
// In the accept cycle of an item every cell compares its value with
// in_value; in the next (busy high) the cells shift in one step and the
// count updates. The result shows in the cycle after, while the next start
// may already be taken; no new item is taken while busy, at any occupancy.
// Synchronous active-low reset empties the store; cell contents are kept.
// The receiver cannot stall: each result is valid for one cycle only.
`default_nettype none
module sorted_unique_set_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [sus_pkg::OP_W-1:0]      in_operation,
  input  wire logic [sus_pkg::VAL_W-1:0]     in_value,
  output logic                               out_strobe,
  output logic      [sus_pkg::ST_W-1:0]      out_status,
  output logic      [sus_pkg::CNT_OUT_W-1:0] out_entry_count
);
  import sus_pkg::*;

  cell_cmd_t          cmd;
  logic [CNT_W-1:0]   count;
  logic [CAPACITY-1:0] occ;
  logic [CAPACITY-1:0] lt_vec;
  logic [CAPACITY-1:0] eq_vec;
  logic [VAL_W-1:0]   val_vec [CAPACITY];
  logic               hit;

  // Reduce the per-cell match flags
  assign hit = |eq_vec;

  sus_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .in_operation    (in_operation),
    .in_value        (in_value),
    .hit             (hit),
    .busy            (busy),
    .cmd             (cmd),
    .count           (count),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_entry_count (out_entry_count)
  );

  // Build the chain; each cell sees its neighbours' values and its left neighbour's less-than flag
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VAL_W-1:0] lv;
    logic             llt;
    logic [VAL_W-1:0] rv;

    assign occ[i] = (CNT_W'(i) < count);

    if (i == 0) begin : g_first
      assign lv  = cmd.key;
      assign llt = 1'b0;
    end else begin : g_mid
      assign lv  = val_vec[i-1];
      assign llt = lt_vec[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign rv = val_vec[i];
    end else begin : g_inner
      assign rv = val_vec[i+1];
    end

    sus_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .occ       (occ[i]),
      .left_val  (lv),
      .left_lt   (llt),
      .right_val (rv),
      .cell_val  (val_vec[i]),
      .cell_lt   (lt_vec[i]),
      .cell_eq   (eq_vec[i])
    );
  end

endmodule
`default_nettype wire
